>>> rtl/mrps_pkg.sv
// Shared constants, types and helpers for the multi-rate poll scheduler.
package mrps_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int MAX_CHAN     = 8;
    localparam int CODE_W       = 8;
    localparam int IDX_W        = 3;
    localparam int SET_W        = 16;
    localparam int CNT_W        = 12;
    localparam int PERIOD_W     = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [SET_W-1:0] SETTING_RESET [MAX_CHAN] = '{
        16'h5005, 16'h1E03, 16'h0A0B, 16'h080C,
        16'h080D, 16'h0A10, 16'h5033, 16'h5042
    };

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  idx;
    } t_emit;

    // Period in 10 ms units to a threshold in ms: p*8 + p*2.
    function automatic logic [CNT_W-1:0] period_limit(input logic [PERIOD_W-1:0] period);
        logic [CNT_W-1:0] p;
        p = CNT_W'(period);
        return (p << 3) + (p << 1);
    endfunction

endpackage

>>> rtl/mrps_cell.sv
// One polling channel: setting, elapsed counter, pending flag and scan token.
module mrps_cell
    import mrps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  logic             i_cfg_we,
    input  logic [SET_W-1:0] i_cfg_wdata,
    input  logic             i_start,
    input  logic             i_step,
    input  logic             i_token,
    output logic             o_token,
    input  logic             i_pend_hi,
    output logic             o_pend_lo,
    input  t_emit            i_emit,
    output t_emit            o_emit
);

    logic [SET_W-1:0] r_setting;
    logic [CNT_W-1:0] r_cnt;
    logic             r_pend;
    logic             r_token;

    logic [CNT_W-1:0] n_cnt;
    logic             fire;

    always_comb begin
        n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
        fire  = n_cnt >= period_limit(r_setting[SET_W-1:CODE_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting <= SETTING_RESET[i_index];
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_token   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_setting <= i_cfg_wdata;
            end
            if (i_start) begin
                r_cnt  <= fire ? '0 : n_cnt;
                r_pend <= fire;
            end else if (i_step && r_token) begin
                r_pend <= 1'b0;
            end
            if (i_step) begin
                r_token <= i_token;
            end
        end
    end

    assign o_token   = r_token;
    assign o_pend_lo = r_pend | i_pend_hi;

    // Claim the emit slot while the token sits on a pending channel.
    always_comb begin
        if (r_token && r_pend) begin
            o_emit.valid = 1'b1;
            o_emit.last  = !i_pend_hi;
            o_emit.code  = r_setting[CODE_W-1:0];
            o_emit.idx   = i_index;
        end else begin
            o_emit = i_emit;
        end
    end

endmodule

>>> rtl/multi_rate_poll_scheduler_top.sv
// Top level of the multi-rate poll scheduler: cell chain, scan control, output register.
//
//   channel  | direction | payload
//   s_axis   | in        | tdata[0] tick
//   m_axis   | out       | tdata[7:0] query_code, tdata[10:8] channel_index, tlast last_of_tick
//   i_cfg_*  | in        | write of channelN_setting, N = i_cfg_idx
//
// A tick is accepted and the scan token then walks the cell chain, one cell per
// cycle while m_axis does not hold it; a zero tick finishes in the accept cycle.
// A held result on m_axis freezes the token on a firing cell until it is taken.
// Reset (synchronous) restores the settings, clears all counters and flags.
module multi_rate_poll_scheduler_top
    import mrps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [0] tick
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] query_code, [10:8] channel_index
    output logic             m_axis_tlast,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [SET_W-1:0] i_cfg_wdata
);

    logic              r_busy;
    logic              r_out_valid;
    logic              r_out_last;
    logic [CODE_W-1:0] r_out_code;
    logic [IDX_W-1:0]  r_out_idx;

    logic  token [NUM_CHANNELS+1];
    logic  pend  [NUM_CHANNELS+1];
    t_emit emit  [NUM_CHANNELS+1];

    logic  start;
    logic  can_load;
    logic  advance;
    logic  step;
    t_emit emit_end;

    assign s_axis_tready = !r_busy;
    assign start         = s_axis_tvalid && s_axis_tready && s_axis_tdata[0];
    assign emit_end      = emit[NUM_CHANNELS];
    assign can_load      = !r_out_valid || m_axis_tready;
    assign advance       = r_busy && (!emit_end.valid || can_load);
    assign step          = start || advance;

    assign token[0]            = start;
    assign pend[NUM_CHANNELS]  = 1'b0;
    assign emit[0]             = '0;

    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
        mrps_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (IDX_W'(i)),
            .i_cfg_we    (i_cfg_we && (i_cfg_idx == IDX_W'(i))),
            .i_cfg_wdata (i_cfg_wdata),
            .i_start     (start),
            .i_step      (step),
            .i_token     (token[i]),
            .o_token     (token[i+1]),
            .i_pend_hi   (pend[i+1]),
            .o_pend_lo   (pend[i]),
            .i_emit      (emit[i]),
            .o_emit      (emit[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (start) begin
                r_busy <= 1'b1;
            end else if (advance && token[NUM_CHANNELS]) begin
                r_busy <= 1'b0;
            end
            if (advance && emit_end.valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit_end.valid) begin
            r_out_last <= emit_end.last;
            r_out_code <= emit_end.code;
            r_out_idx  <= emit_end.idx;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'd0, r_out_idx, r_out_code};

    // pend[0] covers every cell; only the chain into each cell is consumed.
    logic unused_pend;
    assign unused_pend = pend[0];

endmodule
